/* hdl/assert_macros.svh */
// Assertion macros shared by the blur unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define NMB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define NMB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/nmb_pkg.sv */
// Shared constants and types of the neighbour mean blur unit.
package nmb_pkg;

   // defaults for the frame size limits
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   // pixel layout: red in the top byte, blue in the bottom byte
   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 3 * CHAN_W;

   // neighbour mean: eight neighbours, each taken as a floor eighth
   localparam int NEIGHBOURS   = 8;
   localparam int EIGHTH_SHIFT = 3;

   // configuration registers
   localparam int IMG_W_BITS   = 12;
   localparam int IMG_H_BITS   = 13;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam int CSR_IDX_BIT  = 2;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // input word kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // one result word
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              end_of_run;
      logic              end_of_frame;
   } rsp_word_type;

   // up to two result words handed to the output queue in one cycle
   typedef struct packed {
      logic [1:0]   n_words;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_push_type;

endpackage

/* hdl/nmb_req_if.sv */
// Input pixel stream channel of the blur unit.
interface nmb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [nmb_pkg::CHAN_W-1:0] red_in;
   logic [nmb_pkg::CHAN_W-1:0] green_in;
   logic [nmb_pkg::CHAN_W-1:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

/* hdl/nmb_rsp_if.sv */
// Result pixel stream channel of the blur unit.
interface nmb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nmb_pkg::CHAN_W-1:0] red_out;
   logic [nmb_pkg::CHAN_W-1:0] green_out;
   logic [nmb_pkg::CHAN_W-1:0] blue_out;
   logic                      end_of_run;
   logic                      end_of_frame;

   modport source (output valid, red_out, green_out, blue_out, end_of_run, end_of_frame,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, end_of_run, end_of_frame,
                   output ready);
endinterface

/* hdl/nmb_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
module nmb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hdl/nmb_rsp_queue.sv */
// Four-word result queue: takes up to two words a cycle, gives one.
module nmb_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  nmb_pkg::rsp_push_type push,
   output logic                  space_ok,
   nmb_rsp_if.source             rsp_if
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   nmb_pkg::rsp_word_type slot_ff [DEPTH];
   nmb_pkg::rsp_word_type head;
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PW:0]           count_ff, count_in;
   logic                  pop;

   assign pop      = rsp_if.valid & rsp_if.ready;
   assign space_ok = (count_ff <= (PW+1)'(DEPTH - 2));

   // output side
   assign head               = slot_ff[rd_ptr_ff];
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.red_out     = head.red;
   assign rsp_if.green_out   = head.green;
   assign rsp_if.blue_out    = head.blue;
   assign rsp_if.end_of_run  = head.end_of_run;
   assign rsp_if.end_of_frame = head.end_of_frame;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = PW'(wr_ptr_ff + PW'(push.n_words));
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = (PW+1)'(count_ff + (PW+1)'(push.n_words) - (PW+1)'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push.n_words != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.n_words == 2'd2) begin
         slot_ff[PW'(wr_ptr_ff + 1'b1)] <= push.second;
      end
   end

endmodule

/* hdl/neighbour_mean_blur_unit.sv */
// Top level of the neighbour mean blur unit: control, line memory, window and mean.
//
//  channel | direction | word
//  --------+-----------+------------------------------------------------------
//  req_if  | in        | kind, red_in, green_in, blue_in
//  rsp_if  | out       | red_out, green_out, blue_out, end_of_run, end_of_frame
//  csr_*   | in/out    | image_width (addr 0), image_height (addr 4)
//
//  One input word per cycle while the queue has room; results pass the read stage and queue.
//  The rate is set by the single read and write port of the line memory, used once per word.
//  A row end word gives two results into a four-word output queue; rows give as many
//  results as words, so the queue keeps the input flowing while rsp_if is ready.
//  Reset clears counters and handshakes and sets 640x480; the line memory is not cleared.
//  A stall on rsp_if fills the queue, then holds the read stage and drops req_if.ready.
`include "assert_macros.svh"

module neighbour_mean_blur_unit #(
   parameter int MAX_WIDTH  = nmb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = nmb_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   nmb_req_if.sink                      req_if,
   nmb_rsp_if.source                    rsp_if,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [nmb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [nmb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [nmb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int PXW  = nmb_pkg::PIXEL_W;
   localparam int LW   = 2 * PXW;
   localparam int WCMP = ($clog2(MAX_WIDTH + 1) > nmb_pkg::IMG_W_BITS) ?
                         $clog2(MAX_WIDTH + 1) : nmb_pkg::IMG_W_BITS;
   localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > nmb_pkg::IMG_H_BITS) ?
                         $clog2(MAX_HEIGHT + 1) : nmb_pkg::IMG_H_BITS;

   // configuration
   logic [nmb_pkg::IMG_W_BITS-1:0] img_width_ff;
   logic [nmb_pkg::IMG_H_BITS-1:0] img_height_ff;
   logic                           csr_wr;
   logic                           csr_sel_height;
   logic [WCMP-1:0]                width_ext;
   logic [HCMP-1:0]                height_ext;
   logic [AW-1:0]                  wlast;
   logic [RW-1:0]                  hlast;

   // frame position
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] drain_ff, drain_in;
   logic          draining_ff, draining_in;

   // input stage
   logic          accept;
   logic          is_drain;
   logic          take_pixel;
   logic          take_drain;
   logic [AW-1:0] rd_addr;
   logic          fwd_hit;

   // read stage
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_active_ff;
   logic           s1_drain_ff;
   logic [AW-1:0]  s1_addr_ff;
   logic [PXW-1:0] s1_bot_ff;
   logic           s1_emit_a_ff;
   logic           s1_inter_ff;
   logic           s1_emit_b_ff;
   logic           s1_last_ff;
   logic           fwd_sel_ff;
   logic [LW-1:0]  fwd_data_ff;
   logic           s1_fire;
   logic           s1_wr;
   logic [LW-1:0]  ram_rdata;
   logic [LW-1:0]  line_word;
   logic [PXW-1:0] top_px;
   logic [PXW-1:0] mid_px;
   logic [LW-1:0]  wr_data;

   // window and results
   logic [5:0][PXW-1:0]                    win_ff;
   logic [nmb_pkg::NEIGHBOURS-1:0][PXW-1:0] nb;
   logic [PXW-1:0]                         mean_px;
   nmb_pkg::rsp_word_type                  res_a, res_b, res_d;
   nmb_pkg::rsp_push_type                  push;
   logic                                   q_space_ok;

   // per-channel sum of the neighbours' floor eighths
   function automatic logic [PXW-1:0] neighbour_mean(
      input logic [nmb_pkg::NEIGHBOURS-1:0][PXW-1:0] px
   );
      logic [PXW-1:0]             res;
      logic [nmb_pkg::CHAN_W-1:0] acc;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int i = 0; i < nmb_pkg::NEIGHBOURS; i++) begin
            acc = nmb_pkg::CHAN_W'(acc + nmb_pkg::CHAN_W'(
                  px[i][ch*nmb_pkg::CHAN_W + nmb_pkg::EIGHTH_SHIFT +:
                        nmb_pkg::CHAN_W - nmb_pkg::EIGHTH_SHIFT]));
         end
         res[ch*nmb_pkg::CHAN_W +: nmb_pkg::CHAN_W] = acc;
      end
      return res;
   endfunction

   function automatic nmb_pkg::rsp_word_type make_word(
      input logic [PXW-1:0] px,
      input logic           eor,
      input logic           eof
   );
      nmb_pkg::rsp_word_type w;
      w.red          = px[2*nmb_pkg::CHAN_W +: nmb_pkg::CHAN_W];
      w.green        = px[nmb_pkg::CHAN_W +: nmb_pkg::CHAN_W];
      w.blue         = px[0 +: nmb_pkg::CHAN_W];
      w.end_of_run   = eor;
      w.end_of_frame = eof;
      return w;
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready     = 1'b1;
   assign csr_wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel_height = (csr_paddr[nmb_pkg::CSR_IDX_BIT] == nmb_pkg::REG_IMAGE_HEIGHT);
   assign csr_prdata     = csr_sel_height ? nmb_pkg::CSR_DW'(img_height_ff)
                                          : nmb_pkg::CSR_DW'(img_width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= nmb_pkg::IMG_W_BITS'(nmb_pkg::RESET_WIDTH);
         img_height_ff <= nmb_pkg::IMG_H_BITS'(nmb_pkg::RESET_HEIGHT);
      end else if (csr_wr) begin
         if (csr_sel_height) begin
            img_height_ff <= csr_pwdata[nmb_pkg::IMG_H_BITS-1:0];
         end else begin
            img_width_ff <= csr_pwdata[nmb_pkg::IMG_W_BITS-1:0];
         end
      end
   end

   // clamped last column and last row of the frame
   assign width_ext  = WCMP'(img_width_ff);
   assign height_ext = HCMP'(img_height_ff);

   always_comb begin
      if (width_ext == '0) begin
         wlast = '0;
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         wlast = AW'(MAX_WIDTH - 1);
      end else begin
         wlast = AW'(width_ext - WCMP'(1));
      end
      if (height_ext == '0) begin
         hlast = '0;
      end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
         hlast = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast = RW'(height_ext - HCMP'(1));
      end
   end

   // ---------------- input stage ----------------
   assign s1_fire      = s1_valid_ff & q_space_ok;
   assign req_if.ready = ~s1_valid_ff | s1_fire;
   assign accept       = req_if.valid & req_if.ready;
   assign is_drain     = (req_if.kind == nmb_pkg::KIND_DRAIN);
   assign take_pixel   = accept & ~is_drain & ~draining_ff;
   assign take_drain   = accept & is_drain & draining_ff;
   assign rd_addr      = is_drain ? drain_ff : col_ff;

   // same entry written by the read stage this cycle: bypass the memory
   assign s1_wr   = s1_fire & s1_active_ff & ~s1_drain_ff;
   assign fwd_hit = s1_wr & (s1_addr_ff == rd_addr);

   // frame position update
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      if (take_pixel) begin
         if (col_ff == wlast) begin
            col_in = '0;
            if (row_ff == hlast) begin
               draining_in = 1'b1;
               drain_in    = '0;
               row_in      = '0;
            end else begin
               row_in = RW'(row_ff + 1'b1);
            end
         end else begin
            col_in = AW'(col_ff + 1'b1);
         end
      end else if (take_drain) begin
         if (drain_ff == wlast) begin
            drain_in    = '0;
            draining_in = 1'b0;
            row_in      = '0;
            col_in      = '0;
         end else begin
            drain_in = AW'(drain_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
      end
   end

   // ---------------- read stage registers ----------------
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_active_ff <= 1'b0;
         fwd_sel_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            s1_active_ff <= take_pixel | take_drain;
            fwd_sel_ff   <= fwd_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_drain_ff  <= is_drain;
         s1_addr_ff   <= rd_addr;
         s1_bot_ff    <= {req_if.red_in, req_if.green_in, req_if.blue_in};
         s1_emit_a_ff <= (row_ff != '0) && (col_ff != '0);
         s1_inter_ff  <= (row_ff > RW'(1)) && (col_ff > AW'(1));
         s1_emit_b_ff <= (row_ff != '0) && (col_ff == wlast);
         s1_last_ff   <= (drain_ff == wlast);
         fwd_data_ff  <= wr_data;
      end
   end

   // line memory: older row in the upper half, newer row in the lower half
   nmb_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign line_word = fwd_sel_ff ? fwd_data_ff : ram_rdata;
   assign top_px    = line_word[PXW +: PXW];
   assign mid_px    = line_word[0 +: PXW];
   assign wr_data   = {mid_px, s1_bot_ff};

   // ---------------- window and mean ----------------
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= s1_bot_ff;
      end
   end

   // centre (win_ff[4]) left out
   always_comb begin
      nb[0] = win_ff[0];
      nb[1] = win_ff[1];
      nb[2] = win_ff[2];
      nb[3] = win_ff[3];
      nb[4] = win_ff[5];
      nb[5] = top_px;
      nb[6] = mid_px;
      nb[7] = s1_bot_ff;
   end

   assign mean_px = neighbour_mean(nb);

   // ---------------- result words ----------------
   assign res_a = make_word(s1_inter_ff ? mean_px : win_ff[4], ~s1_emit_b_ff, 1'b0);
   assign res_b = make_word(mid_px, 1'b1, 1'b0);
   assign res_d = make_word(mid_px, 1'b1, s1_last_ff);

   always_comb begin
      push.n_words = 2'd0;
      push.first   = res_b;
      push.second  = res_b;
      if (s1_fire && s1_active_ff) begin
         if (s1_drain_ff) begin
            push.first   = res_d;
            push.n_words = 2'd1;
         end else if (s1_emit_a_ff) begin
            push.first   = res_a;
            push.n_words = s1_emit_b_ff ? 2'd2 : 2'd1;
         end else if (s1_emit_b_ff) begin
            push.first   = res_b;
            push.n_words = 2'd1;
         end
      end
   end

   nmb_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (q_space_ok),
      .rsp_if   (rsp_if)
   );

   // ---------------- assertions ----------------
   `NMB_ASSERT_IMPLY(a_drain_pos, clock, reset, draining_ff, (col_ff == '0) && (row_ff == '0), "position not cleared while draining")
   `NMB_ASSERT_ALWAYS(a_col_range, clock, reset, (col_ff <= wlast) && (drain_ff <= wlast), "column beyond frame width")
   `NMB_ASSERT_IMPLY(a_drain_one, clock, reset, s1_fire && s1_active_ff && s1_drain_ff, push.n_words == 2'd1, "drain word must give one result")
   `NMB_ASSERT_NEXT(a_stall_hold, clock, reset, s1_valid_ff && !s1_fire, $stable(fwd_sel_ff) && $stable(s1_addr_ff), "read stage changed while stalled")

endmodule

/* dv/neighbour_mean_blur_unit_tb.sv */
// Testbench of the neighbour mean blur unit: random frames checked word by word against a predictor.
module neighbour_mean_blur_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nmb_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned ROW_LIMIT     = MAX_WIDTH_DEF;
   localparam int unsigned ROWS_LIMIT    = MAX_HEIGHT_DEF;
   localparam int unsigned WIDE_STRETCH  = 256;

   logic clock;
   logic reset;

   nmb_req_if req_bus ();
   nmb_rsp_if rsp_bus ();

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   neighbour_mean_blur_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state: two line stores, 3x2 window, frame position
   logic [PIXEL_W-1:0]    upper_row [ROW_LIMIT];
   logic [PIXEL_W-1:0]    lower_row [ROW_LIMIT];
   logic [PIXEL_W-1:0]    win [6];
   int unsigned           row_at;
   int unsigned           col_at;
   int unsigned           drain_at;
   bit                    in_drain;
   logic [IMG_W_BITS-1:0] width_reg;
   logic [IMG_H_BITS-1:0] height_reg;

   // result words still owed by the block, oldest first
   rsp_word_type outgoing_pixels [$];

   bit          sender_gaps;
   bit          receiver_stalls;
   int unsigned live_words;
   int unsigned words_sent;
   int unsigned pixels_checked;
   int unsigned frames_streamed;
   int unsigned failures;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned top);
      if (raw < 1) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   function automatic void restart_frame();
      row_at   = 0;
      col_at   = 0;
      drain_at = 0;
      in_drain = 1'b0;
      foreach (win[i]) win[i] = '0;
   endfunction

   function automatic void queue_pixel(input logic [PIXEL_W-1:0] pix, input logic last_of_word,
                                       input logic last_of_frame);
      rsp_word_type w;
      w.red          = pix[2*CHAN_W +: CHAN_W];
      w.green        = pix[CHAN_W +: CHAN_W];
      w.blue         = pix[0 +: CHAN_W];
      w.end_of_run   = last_of_word;
      w.end_of_frame = last_of_frame;
      outgoing_pixels.push_back(w);
   endfunction

   // per channel sum of the floor eighths of the eight neighbours
   function automatic logic [PIXEL_W-1:0] mean_of_ring(input logic [PIXEL_W-1:0] ring [8]);
      logic [PIXEL_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < NEIGHBOURS; i++)
         for (int ch = 0; ch < 3; ch++)
            acc[ch*CHAN_W +: CHAN_W] = acc[ch*CHAN_W +: CHAN_W]
                                     + (ring[i][ch*CHAN_W +: CHAN_W] >> EIGHTH_SHIFT);
      return acc;
   endfunction

   // one accepted word: update the window and queue what it produces
   function automatic void advance_blur_window(input logic kind, input logic [PIXEL_W-1:0] bot);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        d;
      int                 n;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] made [2];
      logic [PIXEL_W-1:0] ring [8];
      w = clamp_size(width_reg, ROW_LIMIT);
      h = clamp_size(height_reg, ROWS_LIMIT);
      n = 0;
      if (kind == KIND_DRAIN) begin
         // drain ticks only count once the frame's last pixel is in
         if (in_drain) begin
            live_words++;
            d = (drain_at >= ROW_LIMIT) ? ROW_LIMIT - 1 : drain_at;
            queue_pixel(lower_row[d], 1'b1, d + 1 >= w);
            if (d + 1 >= w) restart_frame();
            else drain_at = d + 1;
         end
      end else if (!in_drain) begin
         live_words++;
         c   = (col_at >= w) ? w - 1 : col_at;
         top = upper_row[c];
         mid = lower_row[c];
         if (row_at >= 1 && c >= 1) begin
            if (row_at >= 2 && c >= 2) begin
               ring = '{win[0], win[1], win[2], win[3], win[5], top, mid, bot};
               made[n] = mean_of_ring(ring);
            end else begin
               made[n] = win[4];
            end
            n++;
         end
         // row end also flushes the last column of the previous row
         if (row_at >= 1 && c == w - 1) begin
            made[n] = mid;
            n++;
         end
         for (int k = 0; k < n; k++) queue_pixel(made[k], k == n - 1, 1'b0);
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = top;
         win[4] = mid;
         win[5] = bot;
         upper_row[c] = mid;
         lower_row[c] = bot;
         if (c + 1 >= w) begin
            col_at = 0;
            if (row_at + 1 >= h) begin
               in_drain = 1'b1;
               drain_at = 0;
               row_at   = 0;
            end else begin
               row_at++;
            end
         end else begin
            col_at = c + 1;
         end
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [PIXEL_W-1:0] pix;
      pix = PIXEL_W'($urandom);
      // a share of pixels with channels at the corners of the range
      if ($urandom_range(0, 9) < 3)
         for (int ch = 0; ch < 3; ch++)
            case ($urandom_range(0, 4))
               0: pix[ch*CHAN_W +: CHAN_W] = 8'h00;
               1: pix[ch*CHAN_W +: CHAN_W] = 8'hFF;
               2: pix[ch*CHAN_W +: CHAN_W] = 8'h07;
               3: pix[ch*CHAN_W +: CHAN_W] = 8'hF8;
               default: ;
            endcase
      return pix;
   endfunction

   // send one input word, predicting at the accepting edge
   task automatic send_word(input logic kind, input logic [PIXEL_W-1:0] pix);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = kind;
      req_bus.red_in   = pix[2*CHAN_W +: CHAN_W];
      req_bus.green_in = pix[CHAN_W +: CHAN_W];
      req_bus.blue_in  = pix[0 +: CHAN_W];
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      words_sent++;
      advance_blur_window(kind, pix);
   endtask

   // APB write, setup then access; upper data bits optionally noisy
   task automatic write_frame_register(input logic idx, input int unsigned raw, input bit noisy);
      logic [CSR_DW-1:0] data;
      data = noisy ? CSR_DW'($urandom) : '0;
      if (idx == REG_IMAGE_WIDTH) data[IMG_W_BITS-1:0] = raw[IMG_W_BITS-1:0];
      else data[IMG_H_BITS-1:0] = raw[IMG_H_BITS-1:0];
      @(negedge clock);
      csr_psel            = 1'b1;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b1;
      csr_paddr           = '0;
      csr_paddr[CSR_IDX_BIT] = idx;
      csr_pwdata          = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[IMG_W_BITS-1:0];
      else height_reg = data[IMG_H_BITS-1:0];
      restart_frame();
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // stop input and let the block finish before touching registers
   task automatic quiesce();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (outgoing_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one frame in raster order plus its drain unless cut short; stray words mixed in
   task automatic stream_frame(input int unsigned w, input int unsigned h, input bit truncate);
      int unsigned total;
      int unsigned stop;
      total = w * h;
      stop  = truncate ? $urandom_range(1, total) : total;
      frames_streamed++;
      for (int unsigned i = 0; i < stop; i++) begin
         if ($urandom_range(0, 40) == 0) send_word(KIND_DRAIN, random_pixel());
         send_word(KIND_PIXEL, random_pixel());
      end
      if (!truncate)
         for (int unsigned k = 0; k < w; k++) begin
            if ($urandom_range(0, 40) == 0) send_word(KIND_PIXEL, random_pixel());
            send_word(KIND_DRAIN, random_pixel());
         end
   endtask

   // reset size 640x480: first row and the start of the second, cut short by a register write
   task automatic test_reset_size();
      for (int i = 0; i < RESET_WIDTH + 3; i++) send_word(KIND_PIXEL, random_pixel());
   endtask

   // 3x3 frame with extreme channels, stray words, then a 1x1 frame from zero sizes
   task automatic test_directed_cases();
      logic [PIXEL_W-1:0] pix;
      quiesce();
      write_frame_register(REG_IMAGE_WIDTH, 3, 1'b0);
      write_frame_register(REG_IMAGE_HEIGHT, 3, 1'b0);
      send_word(KIND_DRAIN, random_pixel());
      // centre dark in red, bright in green: mean must ignore it
      for (int i = 0; i < 9; i++) begin
         pix = (i == 4) ? {8'h00, 8'hFF, 8'hF8} : {8'hFF, 8'h00, 8'h07};
         send_word(KIND_PIXEL, pix);
      end
      send_word(KIND_DRAIN, random_pixel());
      send_word(KIND_DRAIN, random_pixel());
      send_word(KIND_PIXEL, random_pixel());
      send_word(KIND_DRAIN, random_pixel());
      send_word(KIND_DRAIN, random_pixel());
      frames_streamed++;
      quiesce();
      write_frame_register(REG_IMAGE_WIDTH, 0, 1'b0);
      write_frame_register(REG_IMAGE_HEIGHT, 0, 1'b0);
      send_word(KIND_PIXEL, {8'hFF, 8'h00, 8'hA5});
      send_word(KIND_PIXEL, random_pixel());
      send_word(KIND_DRAIN, random_pixel());
      frames_streamed++;
   endtask

   // all-ones registers clamp to the largest frame; a stretch of its first row
   task automatic test_widest_rows();
      quiesce();
      write_frame_register(REG_IMAGE_WIDTH, 32'hFFFF_FFFF, 1'b1);
      write_frame_register(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF, 1'b1);
      for (int unsigned i = 0; i < WIDE_STRETCH; i++) send_word(KIND_PIXEL, random_pixel());
      frames_streamed++;
   endtask

   // random small frames, now and then cut short, until enough words took effect
   task automatic test_random_frames(input int unsigned word_goal, input bit allow_gaps);
      int unsigned start;
      int unsigned w_raw;
      int unsigned h_raw;
      int unsigned r;
      start = live_words;
      while (live_words - start < word_goal) begin
         r = $urandom_range(0, 19);
         if (r < 10) w_raw = $urandom_range(1, 8);
         else if (r < 16) w_raw = $urandom_range(9, 40);
         else if (r < 18) w_raw = $urandom_range(41, 160);
         else if (r == 18) w_raw = 0;
         else w_raw = $urandom_range(1, 2);
         r = $urandom_range(0, 19);
         if (r < 12) h_raw = $urandom_range(1, 4);
         else if (r < 17) h_raw = $urandom_range(5, 10);
         else if (r == 17) h_raw = 0;
         else h_raw = 1;
         if (w_raw > 40) h_raw = $urandom_range(1, 3);
         quiesce();
         r = $urandom_range(0, 9);
         if (r == 0) begin
            write_frame_register(REG_IMAGE_HEIGHT, h_raw, 1'($urandom_range(0, 1)));
         end else if (r == 1) begin
            write_frame_register(REG_IMAGE_WIDTH, w_raw, 1'($urandom_range(0, 1)));
         end else if (r == 2) begin
            write_frame_register(REG_IMAGE_HEIGHT, h_raw, 1'($urandom_range(0, 1)));
            write_frame_register(REG_IMAGE_WIDTH, w_raw, 1'($urandom_range(0, 1)));
         end else begin
            write_frame_register(REG_IMAGE_WIDTH, w_raw, 1'($urandom_range(0, 1)));
            write_frame_register(REG_IMAGE_HEIGHT, h_raw, 1'($urandom_range(0, 1)));
         end
         sender_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
         stream_frame(clamp_size(width_reg, ROW_LIMIT), clamp_size(height_reg, ROWS_LIMIT),
                      $urandom_range(0, 7) == 0);
      end
   endtask

   // result side ready: stall bursts with calm stretches between them
   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      stall_left    = 0;
      calm_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm_left > 0) calm_left--;
         else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(20, 120);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (receiver_stalls && calm_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left    = $urandom_range(0, 5);
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   function automatic void compare_field(input string name, input logic [CHAN_W-1:0] want,
                                         input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // check each accepted result word against the oldest one owed
   always @(posedge clock) begin : check_result
      rsp_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (outgoing_pixels.size() == 0) begin
            $error("result word with none owed: %0h %0h %0h", rsp_bus.red_out,
                   rsp_bus.green_out, rsp_bus.blue_out);
            failures++;
         end else begin
            want = outgoing_pixels.pop_front();
            pixels_checked++;
            compare_field("red_out", want.red, rsp_bus.red_out);
            compare_field("green_out", want.green, rsp_bus.green_out);
            compare_field("blue_out", want.blue, rsp_bus.blue_out);
            compare_field("end_of_run", want.end_of_run, rsp_bus.end_of_run);
            compare_field("end_of_frame", want.end_of_frame, rsp_bus.end_of_frame);
         end
      end
   end

   // watchdog: too long with no word moving on any port
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
             || (csr_psel === 1'b1 && csr_penable === 1'b1 && csr_pready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout with %0d result words owed", outgoing_pixels.size());
      $display("[neighbour_mean_blur_unit] ERROR");
      $finish;
   end

   // test sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_PIXEL;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      width_reg        = IMG_W_BITS'(RESET_WIDTH);
      height_reg       = IMG_H_BITS'(RESET_HEIGHT);
      foreach (upper_row[i]) upper_row[i] = '0;
      foreach (lower_row[i]) lower_row[i] = '0;
      restart_frame();
      sender_gaps      = 1'b1;
      receiver_stalls  = 1'b1;
      live_words       = 0;
      words_sent       = 0;
      pixels_checked   = 0;
      frames_streamed  = 0;
      failures         = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_size();
      test_directed_cases();
      test_widest_rows();
      test_random_frames(450, 1'b1);
      // closing stretch at full rate on both sides
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      test_random_frames(150, 1'b0);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (outgoing_pixels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("%0d frames, %0d input words (%0d took effect), %0d result words checked",
               frames_streamed, words_sent, live_words, pixels_checked);
      $display("sizes from 1x1 to 160 wide, clamped registers, stray drain ticks and pixels");
      if (failures == 0)
         $display("[neighbour_mean_blur_unit] OK");
      else
         $display("[neighbour_mean_blur_unit] ERROR");
      $finish;
   end

endmodule
